// File: rtl/spn_pkg.sv
// shared types and constants for the spn block cipher core
`timescale 1ns / 1ps

package spn_pkg;

  localparam int unsigned DEF_ROUNDS      = 16;
  localparam int unsigned DEF_PERM_PERIOD = 2;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned PERM_W   = 5;

  localparam logic [OPCODE_W-1:0] OP_LOAD_SUB  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_PERM = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LOAD_KEY  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ENCRYPT   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DECRYPT   = 3'd4;

  // byte k of the block sits at index ~k, nibble n at index ~n
  typedef logic [15:0][BYTE_W-1:0] byte_blk_t;
  typedef logic [31:0][3:0]        nib_blk_t;

  typedef struct packed {
    logic              sub_we;
    logic              perm_we;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] val;
  } tab_wr_t;

  typedef struct packed {
    logic              inv;
    logic [BYTE_W-1:0] addr0;
    logic [BYTE_W-1:0] addr1;
  } sbox_req_t;

  typedef struct packed {
    logic start;
    logic inv;
  } perm_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } perm_stat_t;

endpackage

// File: rtl/spn_if.sv
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps

interface spn_in_if;
  logic                              valid;
  logic                              ready;
  logic [spn_pkg::OPCODE_W-1:0]      opcode;
  logic [spn_pkg::BYTE_W-1:0]        table_index;
  logic [spn_pkg::BYTE_W-1:0]        table_value;
  logic [spn_pkg::HALF_W-1:0]        block_hi;
  logic [spn_pkg::HALF_W-1:0]        block_lo;

  modport source (output valid, opcode, table_index, table_value, block_hi, block_lo,
                  input ready);
  modport sink (input valid, opcode, table_index, table_value, block_hi, block_lo,
                output ready);
endinterface

interface spn_out_if;
  logic                         valid;
  logic                         ready;
  logic [spn_pkg::HALF_W-1:0]   result_hi;
  logic [spn_pkg::HALF_W-1:0]   result_lo;

  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface

// File: rtl/spn_block_cipher_core.sv
// top level of the spn block cipher core: round sequencer, block state and key store
`timescale 1ns / 1ps

// Load transactions (substitution entry, permutation entry, key byte) are accepted while
// the core is idle and return nothing. An encrypt or decrypt transaction runs ROUNDS
// rounds on one block and returns one result; the core is not ready while a block is in
// progress. A round has a substitution step, which goes through two-port forward and
// inverse table RAMs at two bytes per cycle, a mixing step and a key XOR. A round that
// permutes nibbles also waits for the scatter unit, which moves one nibble per cycle,
// and then collects its output. When all rounds are done the block is handed to the
// output register, after which the core is ready again. The finished block waits in that
// register until its result transaction; a later block that finishes before then waits
// in the core. Tables hold whatever was last loaded and must be filled before use.
module spn_block_cipher_core #(
  parameter int unsigned ROUNDS      = spn_pkg::DEF_ROUNDS,
  parameter int unsigned PERM_PERIOD = spn_pkg::DEF_PERM_PERIOD
) (
  input  logic       clk,
  input  logic       rst_n,
  spn_in_if.sink     in_ch,
  spn_out_if.source  out_ch
);

  localparam int unsigned RND_W    = $clog2(ROUNDS);
  localparam logic [3:0]  SUB_LAST = 4'd8;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUB   = 6'b000010,
    S_MIX   = 6'b000100,
    S_PWAIT = 6'b001000,
    S_KEY   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                 state_r;
  state_t                 state_nxt;
  spn_pkg::byte_blk_t     st_r;
  spn_pkg::byte_blk_t     st_nxt;
  logic                   dec_r;
  logic                   dec_nxt;
  logic [RND_W-1:0]       rnd_r;
  logic [RND_W-1:0]       rnd_nxt;
  logic [3:0]             sub_cnt_r;
  logic [3:0]             sub_cnt_nxt;
  spn_pkg::byte_blk_t     key_mem [ROUNDS];
  spn_pkg::byte_blk_t     key_q_r;
  spn_pkg::byte_blk_t     out_blk_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   out_load;

  logic                   in_acc;
  spn_pkg::tab_wr_t       tab_wr;
  spn_pkg::sbox_req_t     sbox_req;
  logic [7:0]             sbox_rd0;
  logic [7:0]             sbox_rd1;
  spn_pkg::perm_ctrl_t    perm_ctrl;
  spn_pkg::perm_stat_t    perm_stat;
  spn_pkg::nib_blk_t      perm_dst;
  logic [ROUNDS-1:0]      perm_rnd;
  logic                   is_perm;
  logic                   is_slide;
  logic [3:0]             rd_k0;
  logic [3:0]             rd_k1;
  logic [2:0]             wr_pair;
  logic [3:0]             wr_k0;
  logic [3:0]             wr_k1;

  function automatic spn_pkg::byte_blk_t slide_fwd(spn_pkg::byte_blk_t x);
    logic [7:0]         acc;
    spn_pkg::byte_blk_t o;
    acc = x[15];
    o   = x;
    for (int i = 1; i < 16; i++) begin
      acc   = acc ^ x[15-i];
      o[15-i] = acc;
    end
    o[15] = x[15] ^ acc;
    return o;
  endfunction

  function automatic spn_pkg::byte_blk_t slide_bwd(spn_pkg::byte_blk_t x);
    spn_pkg::byte_blk_t o;
    o     = x;
    o[15] = x[15] ^ x[0];
    o[14] = x[14] ^ o[15];
    for (int i = 2; i < 16; i++) begin
      o[15-i] = x[15-i] ^ x[16-i];
    end
    return o;
  endfunction

  for (genvar g = 0; g < ROUNDS; g++) begin : g_kind
    assign perm_rnd[g] = ((g + 1) % PERM_PERIOD == 0) && ((g + 1) % 4 != 0);
  end

  assign is_perm  = perm_rnd[rnd_r];
  assign is_slide = (rnd_r[1:0] == 2'b11);

  assign in_acc        = in_ch.valid && in_ch.ready;
  assign tab_wr.sub_we  = in_acc && (in_ch.opcode == spn_pkg::OP_LOAD_SUB);
  assign tab_wr.perm_we = in_acc && (in_ch.opcode == spn_pkg::OP_LOAD_PERM);
  assign tab_wr.idx     = in_ch.table_index;
  assign tab_wr.val     = in_ch.table_value;

  // substitution walk: issue a byte pair per cycle, write back the pair issued before
  assign rd_k0   = {sub_cnt_r[2:0], 1'b0};
  assign rd_k1   = {sub_cnt_r[2:0], 1'b1};
  assign wr_pair = 3'(sub_cnt_r - 4'd1);
  assign wr_k0   = {wr_pair, 1'b0};
  assign wr_k1   = {wr_pair, 1'b1};

  assign sbox_req.inv   = dec_r;
  assign sbox_req.addr0 = st_r[~rd_k0];
  assign sbox_req.addr1 = st_r[~rd_k1];

  spn_sbox u_sbox (
    .clk    (clk),
    .wr     (tab_wr),
    .req    (sbox_req),
    .rdata0 (sbox_rd0),
    .rdata1 (sbox_rd1)
  );

  spn_perm u_perm (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tab_wr),
    .ctrl  (perm_ctrl),
    .src   (st_r),
    .stat  (perm_stat),
    .dst   (perm_dst)
  );

  // finished block moves to the output register once that is free or being emptied
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt       = state_r;
    st_nxt          = st_r;
    dec_nxt         = dec_r;
    rnd_nxt         = rnd_r;
    sub_cnt_nxt     = sub_cnt_r;
    perm_ctrl.start = 1'b0;
    perm_ctrl.inv   = dec_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_ch.opcode == spn_pkg::OP_ENCRYPT) begin
            st_nxt      = {in_ch.block_hi, in_ch.block_lo};
            dec_nxt     = 1'b0;
            rnd_nxt     = '0;
            sub_cnt_nxt = '0;
            state_nxt   = S_SUB;
          end else if (in_ch.opcode == spn_pkg::OP_DECRYPT) begin
            st_nxt      = {in_ch.block_hi, in_ch.block_lo};
            dec_nxt     = 1'b1;
            rnd_nxt     = RND_W'(ROUNDS - 1);
            sub_cnt_nxt = '0;
            state_nxt   = S_KEY;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SUB: begin
        if (sub_cnt_r != '0) begin
          st_nxt[~wr_k0] = sbox_rd0;
          st_nxt[~wr_k1] = sbox_rd1;
        end
        if (sub_cnt_r == SUB_LAST) begin
          sub_cnt_nxt = '0;
          priority if (!dec_r) begin
            state_nxt = S_MIX;
          end else if (rnd_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            rnd_nxt   = rnd_r - 1'b1;
            state_nxt = S_KEY;
          end
        end else begin
          sub_cnt_nxt = sub_cnt_r + 4'd1;
        end
      end
      S_MIX: begin
        if (is_perm) begin
          perm_ctrl.start = 1'b1;
          state_nxt       = S_PWAIT;
        end else begin
          if (is_slide) begin
            st_nxt = dec_r ? slide_bwd(st_r) : slide_fwd(st_r);
          end
          state_nxt = dec_r ? S_SUB : S_KEY;
        end
      end
      S_PWAIT: begin
        if (perm_stat.done) begin
          st_nxt    = perm_dst;
          state_nxt = dec_r ? S_SUB : S_KEY;
        end
      end
      S_KEY: begin
        st_nxt = st_r ^ key_q_r;
        priority if (dec_r) begin
          state_nxt = S_MIX;
        end else if (rnd_r == RND_W'(ROUNDS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          rnd_nxt   = rnd_r + 1'b1;
          state_nxt = S_SUB;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dec_r       <= 1'b0;
      rnd_r       <= '0;
      sub_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dec_r       <= dec_nxt;
      rnd_r       <= rnd_nxt;
      sub_cnt_r   <= sub_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_blk_r <= st_r;
    end
  end

  // round keys: one row of 16 bytes per round, rows past the last round are dropped
  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.opcode == spn_pkg::OP_LOAD_KEY) &&
        (32'(in_ch.table_index[7:4]) < ROUNDS)) begin
      key_mem[RND_W'(in_ch.table_index[7:4])][~in_ch.table_index[3:0]] <= in_ch.table_value;
    end
  end

  always_ff @(posedge clk) begin
    key_q_r <= key_mem[rnd_nxt];
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.result_hi = out_blk_r[15:8];
  assign out_ch.result_lo = out_blk_r[7:0];

  a_sub_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUB |-> sub_cnt_r <= SUB_LAST)
    else $error("substitution pair counter out of range");

  a_perm_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    perm_stat.done |-> state_r == S_PWAIT)
    else $error("permutation finished outside its wait state");

  a_perm_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PWAIT && !perm_stat.done |-> perm_stat.busy)
    else $error("waiting on a permutation that is not running");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_blk_r))
    else $error("pending result transaction changed or dropped");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready &&
    (in_ch.opcode == spn_pkg::OP_ENCRYPT || in_ch.opcode == spn_pkg::OP_DECRYPT)
    |=> state_r == S_SUB || state_r == S_KEY)
    else $error("block transaction did not start a round");

endmodule

// File: rtl/spn_sbox.sv
// byte substitution tables and their inverse, two registered lookups per cycle
`timescale 1ns / 1ps

module spn_sbox (
  input  logic                         clk,
  input  spn_pkg::tab_wr_t             wr,
  input  spn_pkg::sbox_req_t           req,
  output logic [spn_pkg::BYTE_W-1:0]   rdata0,
  output logic [spn_pkg::BYTE_W-1:0]   rdata1
);

  logic [spn_pkg::BYTE_W-1:0] sub_mem [256];
  logic [spn_pkg::BYTE_W-1:0] inv_mem [256];
  logic [spn_pkg::BYTE_W-1:0] rdata0_r;
  logic [spn_pkg::BYTE_W-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (wr.sub_we) begin
      sub_mem[wr.idx] <= wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.sub_we) begin
      inv_mem[wr.val] <= wr.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (req.inv) begin
      rdata0_r <= inv_mem[req.addr0];
      rdata1_r <= inv_mem[req.addr1];
    end else begin
      rdata0_r <= sub_mem[req.addr0];
      rdata1_r <= sub_mem[req.addr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// File: rtl/spn_perm.sv
// nibble permutation tables and serial scatter unit, one nibble per cycle
`timescale 1ns / 1ps

module spn_perm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spn_pkg::tab_wr_t      wr,
  input  spn_pkg::perm_ctrl_t   ctrl,
  input  spn_pkg::nib_blk_t     src,
  output spn_pkg::perm_stat_t   stat,
  output spn_pkg::nib_blk_t     dst
);

  logic [spn_pkg::PERM_W-1:0] perm_tab_r [32];
  logic [spn_pkg::PERM_W-1:0] inv_tab_r  [32];

  logic                       run_r;
  logic                       run_nxt;
  logic                       done_r;
  logic                       done_nxt;
  logic                       inv_r;
  logic                       inv_nxt;
  logic [spn_pkg::PERM_W-1:0] cnt_r;
  logic [spn_pkg::PERM_W-1:0] cnt_nxt;
  logic [spn_pkg::PERM_W-1:0] dest;
  spn_pkg::nib_blk_t          dst_r;

  always_ff @(posedge clk) begin
    if (wr.perm_we) begin
      perm_tab_r[wr.idx[spn_pkg::PERM_W-1:0]] <= wr.val[spn_pkg::PERM_W-1:0];
      inv_tab_r[wr.val[spn_pkg::PERM_W-1:0]]  <= wr.idx[spn_pkg::PERM_W-1:0];
    end
  end

  assign dest = inv_r ? inv_tab_r[cnt_r] : perm_tab_r[cnt_r];

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    inv_nxt  = inv_r;
    cnt_nxt  = cnt_r;
    if (ctrl.start) begin
      run_nxt = 1'b1;
      inv_nxt = ctrl.inv;
      cnt_nxt = '0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      inv_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      inv_r  <= inv_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // later source nibbles overwrite earlier ones on a clash
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dst_r <= '0;
    end else if (run_r) begin
      dst_r[~dest] <= src[~cnt_r];
    end
  end

  assign dst       = dst_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

// File: tb/spn_block_cipher_core_tb.sv
// self-checking testbench for the spn block cipher core: queue-fed driver, monitor, block predictor
`timescale 1ns / 1ps

module spn_block_cipher_core_tb;

  localparam int unsigned N_ROUNDS = spn_pkg::DEF_ROUNDS;
  localparam int unsigned N_PERIOD = spn_pkg::DEF_PERM_PERIOD;
  localparam logic [spn_pkg::OPCODE_W-1:0] OP_TOP = 3'd7;
  localparam int RANDOM_ITEMS = 180;
  localparam int QUIET_TAIL = 40;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam logic [spn_pkg::HALF_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [spn_pkg::OPCODE_W-1:0] opcode;
    logic [spn_pkg::BYTE_W-1:0]   idx;
    logic [spn_pkg::BYTE_W-1:0]   val;
    logic [spn_pkg::HALF_W-1:0]   hi;
    logic [spn_pkg::HALF_W-1:0]   lo;
    logic                         use_cipher;
  } cmd_t;

  logic clk;
  logic rst_n;

  spn_in_if  in_ch ();
  spn_out_if out_ch ();

  spn_block_cipher_core #(
    .ROUNDS      (N_ROUNDS),
    .PERM_PERIOD (N_PERIOD)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cmd_t         pending_cmds[$];
  logic [127:0] expected_blocks[$];

  logic [spn_pkg::BYTE_W-1:0] sbox_fwd [256];
  logic [spn_pkg::BYTE_W-1:0] sbox_inv [256];
  logic [spn_pkg::BYTE_W-1:0] key_mem  [256];
  logic [spn_pkg::PERM_W-1:0] nperm_fwd [32];
  logic [spn_pkg::PERM_W-1:0] nperm_inv [32];

  logic [127:0] last_cipher = '0;
  logic [127:0] want_blk;
  cmd_t         cur_cmd;
  bit           sending;
  bit           calm;
  bit           quiet;
  int           in_gap;
  int           out_gap;
  int           mismatches = 0;
  int           stall_cycles;
  int           calm_timer;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [127:0] sub_layer(input logic [127:0] s, input bit inv);
    logic [127:0] d;
    logic [7:0]   x;
    d = s;
    for (int k = 0; k < 16; k++) begin
      x = s[127-8*k -: 8];
      d[127-8*k -: 8] = inv ? sbox_inv[x] : sbox_fwd[x];
    end
    return d;
  endfunction

  // scatter: nibble i moves to position perm[i], unreached positions stay zero
  function automatic logic [127:0] nibble_scatter(input logic [127:0] s, input bit inv);
    logic [127:0] d;
    logic [4:0]   p;
    d = '0;
    for (int i = 0; i < 32; i++) begin
      p = inv ? nperm_inv[i] : nperm_fwd[i];
      d[127-4*p -: 4] = s[127-4*i -: 4];
    end
    return d;
  endfunction

  function automatic logic [127:0] xor_slide(input logic [127:0] s, input bit inv);
    logic [7:0]   b [16];
    logic [127:0] d;
    for (int k = 0; k < 16; k++) b[k] = s[127-8*k -: 8];
    if (!inv) begin
      for (int i = 0; i < 15; i++) b[i+1] = b[i+1] ^ b[i];
      b[0] = b[0] ^ b[15];
    end else begin
      b[0] = b[0] ^ b[15];
      for (int i = 15; i > 0; i--) b[i] = b[i] ^ b[i-1];
    end
    for (int k = 0; k < 16; k++) d[127-8*k -: 8] = b[k];
    return d;
  endfunction

  function automatic logic [127:0] add_round_key(input logic [127:0] s, input int r);
    logic [127:0] d;
    d = s;
    for (int k = 0; k < 16; k++)
      d[127-8*k -: 8] = s[127-8*k -: 8] ^ key_mem[((r - 1) * 16 + k) & 255];
    return d;
  endfunction

  function automatic bit perm_round(input int r);
    return (r % N_PERIOD == 0) && (r % 4 != 0);
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] s);
    logic [127:0] d;
    d = s;
    for (int r = 1; r <= N_ROUNDS; r++) begin
      d = sub_layer(d, 1'b0);
      if (perm_round(r)) d = nibble_scatter(d, 1'b0);
      else if (r % 4 == 0) d = xor_slide(d, 1'b0);
      d = add_round_key(d, r);
    end
    return d;
  endfunction

  function automatic logic [127:0] decrypt_block(input logic [127:0] s);
    logic [127:0] d;
    d = s;
    for (int r = N_ROUNDS; r > 0; r--) begin
      d = add_round_key(d, r);
      if (perm_round(r)) d = nibble_scatter(d, 1'b1);
      else if (r % 4 == 0) d = xor_slide(d, 1'b1);
      d = sub_layer(d, 1'b1);
    end
    return d;
  endfunction

  task automatic apply_cmd(input cmd_t c);
    logic [127:0] blk;
    blk = {c.hi, c.lo};
    case (c.opcode)
      spn_pkg::OP_LOAD_SUB: begin
        sbox_fwd[c.idx] = c.val;
        sbox_inv[c.val] = c.idx;
      end
      spn_pkg::OP_LOAD_PERM: begin
        nperm_fwd[c.idx[4:0]] = c.val[4:0];
        nperm_inv[c.val[4:0]] = c.idx[4:0];
      end
      spn_pkg::OP_LOAD_KEY: key_mem[c.idx] = c.val;
      spn_pkg::OP_ENCRYPT: begin
        blk = encrypt_block(blk);
        last_cipher = blk;
        expected_blocks.insert(expected_blocks.size(), blk);
      end
      spn_pkg::OP_DECRYPT: begin
        expected_blocks.insert(expected_blocks.size(), decrypt_block(blk));
      end
      default: ;
    endcase
  endtask

  function automatic logic [spn_pkg::HALF_W-1:0] rand_half();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_cmd(input logic [spn_pkg::OPCODE_W-1:0] op, input logic [7:0] ix,
                           input logic [7:0] vx, input logic [63:0] hi,
                           input logic [63:0] lo, input bit chain);
    cmd_t c;
    c.opcode     = op;
    c.idx        = ix;
    c.val        = vx;
    c.hi         = hi;
    c.lo         = lo;
    c.use_cipher = chain;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic queue_block(input logic [spn_pkg::OPCODE_W-1:0] op, input bit chain);
    queue_cmd(op, 8'($urandom), 8'($urandom), rand_half(), rand_half(), chain);
  endtask

  // full bijective load; permutation loads get random upper bits that the core drops
  task automatic queue_bijection(input logic [spn_pkg::OPCODE_W-1:0] op, input int n);
    int         vals [256];
    int         j;
    int         t;
    logic [7:0] ix;
    logic [7:0] vx;
    for (int i = 0; i < n; i++) vals[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = vals[i];
      vals[i] = vals[j];
      vals[j] = t;
    end
    for (int i = 0; i < n; i++) begin
      ix = 8'(i);
      vx = 8'(vals[i]);
      if (n < 256) begin
        ix[7:5] = 3'($urandom_range(0, 7));
        vx[7:5] = 3'($urandom_range(0, 7));
      end
      queue_cmd(op, ix, vx, rand_half(), rand_half(), 1'b0);
    end
  endtask

  task automatic queue_keys();
    for (int i = 0; i < 256; i++)
      queue_cmd(spn_pkg::OP_LOAD_KEY, 8'(i), 8'($urandom), rand_half(), rand_half(), 1'b0);
  endtask

  task automatic note_mismatch(input string what, input logic [127:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t %s: result_hi exp %h got %h, result_lo exp %h got %h", $realtime, what,
               want[127:64], out_ch.result_hi, want[63:0], out_ch.result_lo);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      sending = 1'b0;
      in_gap  = 0;
      in_ch.valid       <= 1'b0;
      in_ch.opcode      <= '0;
      in_ch.table_index <= '0;
      in_ch.table_value <= '0;
      in_ch.block_hi    <= '0;
      in_ch.block_lo    <= '0;
      quiet <= 1'b0;
    end else begin
      quiet <= (pending_cmds.size() < QUIET_TAIL);
      if (in_ch.valid && in_ch.ready) begin
        apply_cmd(cur_cmd);
        sending = 1'b0;
      end
      if (!sending) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_cmds.size() != 0) begin
          if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(0, 9);
          end else begin
            cur_cmd = pending_cmds.pop_front();
            if (cur_cmd.use_cipher) {cur_cmd.hi, cur_cmd.lo} = last_cipher;
            in_ch.opcode      <= cur_cmd.opcode;
            in_ch.table_index <= cur_cmd.idx;
            in_ch.table_value <= cur_cmd.val;
            in_ch.block_hi    <= cur_cmd.hi;
            in_ch.block_lo    <= cur_cmd.lo;
            sending = 1'b1;
          end
        end
      end
      in_ch.valid <= sending;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_gap = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_blocks.size() == 0) begin
          note_mismatch("unexpected transaction", 128'b0);
        end else begin
          want_blk = expected_blocks.pop_front();
          if (out_ch.result_hi !== want_blk[127:64] || out_ch.result_lo !== want_blk[63:0])
            note_mismatch("result mismatch", want_blk);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog and stall-mode switching
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
      calm_timer   <= 0;
      calm         <= 1'b0;
    end else begin
      calm_timer <= calm_timer + 1;
      if (calm_timer % 256 == 255) calm <= ($urandom_range(0, 3) == 0);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    rst_n = 1'b0;

    // unused opcodes before anything is loaded
    for (int op = spn_pkg::OP_DECRYPT + 1; op <= OP_TOP; op++)
      queue_cmd(3'(op), 8'hFF, 8'hFF, ALL_ONES, ALL_ONES, 1'b0);

    queue_bijection(spn_pkg::OP_LOAD_SUB, 256);
    queue_bijection(spn_pkg::OP_LOAD_PERM, 32);
    queue_keys();

    queue_cmd(spn_pkg::OP_ENCRYPT, 8'h00, 8'h00, '0, '0, 1'b0);
    queue_cmd(spn_pkg::OP_DECRYPT, 8'h00, 8'h00, '0, '0, 1'b1);
    queue_cmd(spn_pkg::OP_ENCRYPT, 8'hFF, 8'hFF, ALL_ONES, ALL_ONES, 1'b0);
    queue_cmd(spn_pkg::OP_DECRYPT, 8'hFF, 8'hFF, ALL_ONES, ALL_ONES, 1'b1);
    queue_cmd(spn_pkg::OP_ENCRYPT, 8'h00, 8'hFF, '0, ALL_ONES, 1'b0);
    queue_cmd(spn_pkg::OP_DECRYPT, 8'hFF, 8'h00, ALL_ONES, '0, 1'b0);
    queue_cmd(spn_pkg::OP_DECRYPT, 8'h00, 8'h00, '0, '0, 1'b0);
    queue_cmd(spn_pkg::OP_DECRYPT, 8'hFF, 8'hFF, ALL_ONES, ALL_ONES, 1'b0);

    // key extremes
    queue_cmd(spn_pkg::OP_LOAD_KEY, 8'h00, 8'hFF, '0, '0, 1'b0);
    queue_cmd(spn_pkg::OP_LOAD_KEY, 8'hFF, 8'h00, ALL_ONES, ALL_ONES, 1'b0);
    queue_block(spn_pkg::OP_ENCRYPT, 1'b0);
    queue_block(spn_pkg::OP_DECRYPT, 1'b1);

    // out-of-range permutation entries, both landing on nibble 27
    queue_cmd(spn_pkg::OP_LOAD_PERM, 8'hE3, 8'hFB, '0, '0, 1'b0);
    queue_cmd(spn_pkg::OP_LOAD_PERM, 8'h24, 8'h1B, ALL_ONES, ALL_ONES, 1'b0);
    queue_block(spn_pkg::OP_ENCRYPT, 1'b0);
    queue_block(spn_pkg::OP_DECRYPT, 1'b1);
    queue_block(spn_pkg::OP_DECRYPT, 1'b0);

    // substitution table no longer a bijection
    queue_cmd(spn_pkg::OP_LOAD_SUB, 8'h00, 8'hFF, '0, '0, 1'b0);
    queue_cmd(spn_pkg::OP_LOAD_SUB, 8'hFF, 8'hFF, ALL_ONES, ALL_ONES, 1'b0);
    queue_block(spn_pkg::OP_ENCRYPT, 1'b0);
    queue_block(spn_pkg::OP_DECRYPT, 1'b1);
    queue_block(3'($urandom_range(spn_pkg::OP_DECRYPT + 1, OP_TOP)), 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)      queue_block(spn_pkg::OP_ENCRYPT, 1'b0);
      else if (roll < 55) queue_block(spn_pkg::OP_DECRYPT, 1'b1);
      else if (roll < 70) queue_block(spn_pkg::OP_DECRYPT, 1'b0);
      else if (roll < 80) queue_block(spn_pkg::OP_LOAD_KEY, 1'b0);
      else if (roll < 87) queue_block(spn_pkg::OP_LOAD_SUB, 1'b0);
      else if (roll < 95) queue_block(spn_pkg::OP_LOAD_PERM, 1'b0);
      else                queue_block(3'($urandom_range(spn_pkg::OP_DECRYPT + 1, OP_TOP)), 1'b0);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_cmds.size() != 0 || sending || expected_blocks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: spn_block_cipher_core.f
rtl/spn_pkg.sv
rtl/spn_if.sv
rtl/spn_sbox.sv
rtl/spn_perm.sv
rtl/spn_block_cipher_core.sv
tb/spn_block_cipher_core_tb.sv
